@@ hdl/egc_pkg.sv @@
// Shared types, constants and elaboration-time table builders for the coordinate converter.
package egc_pkg;

  // Signed 64-bit word: Q60 vector components and 2^64-per-turn phases
  typedef logic signed [63:0] word_t;

  // Working state of one CORDIC cell
  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
  } cordic_t;

  localparam int CORDIC_IT = 60;
  localparam int VEC_FRAC  = 60;
  localparam int COEF_FRAC = 58;
  localparam int SMUL_LAT  = 4;

  localparam logic [63:0] TWO_OVER_PI = 64'hA2F9836E4E44152A;
  localparam logic [127:0] POW5_10 = 128'd9765625;

  // Rotation matrix entries in units of 1e-10, row major
  localparam word_t COEF_DEC [9] = '{
    -64'sd548755604,  64'sd4941094279, -64'sd8676661490,
    -64'sd8734370902, -64'sd4448296300, -64'sd1980763734,
    -64'sd4838350155,  64'sd7469822445,  64'sd4559837762
  };

  // Rounded scaled product, ties away from zero; used for constant setup only
  function automatic word_t smul_c(word_t a, word_t b, int s);
    logic         neg;
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] prod;
    logic [62:0]  r;
    neg  = a[63] ^ b[63];
    ua   = a[63] ? 64'd0 - a : a;
    ub   = b[63] ? 64'd0 - b : b;
    prod = {64'd0, ua} * {64'd0, ub};
    prod = prod + (128'd1 << (s - 1));
    prod = prod >> s;
    r    = prod[62:0];
    return neg ? word_t'(64'd0 - {1'b0, r}) : word_t'({1'b0, r});
  endfunction

  // Inverse CORDIC gain in Q60 by Newton iteration
  function automatic word_t gain_calc();
    word_t p;
    word_t y;
    word_t t;
    p = word_t'(64'd1 << 60);
    for (int i = 0; i < CORDIC_IT; i++) begin
      if (2 * i < 63) begin
        p = p + (p >>> (2 * i));
      end
    end
    y = word_t'(64'd1 << 59);
    for (int i = 0; i < 8; i++) begin
      t = smul_c(y, y, VEC_FRAC);
      t = smul_c(p, t, VEC_FRAC);
      t = word_t'(64'd3 << 60) - t;
      y = smul_c(y, t, VEC_FRAC + 1);
    end
    return y;
  endfunction

  localparam word_t GAIN_K = gain_calc();

  // atan(2^-i) as a phase, full turn = 2^64
  function automatic logic [63:0] atan_entry(int i);
    logic [63:0]  r;
    logic [63:0]  term;
    logic [127:0] prod;
    logic [63:0]  hi;
    logic         done;
    int           e;
    if (i == 0) begin
      return 64'd1 << 61;
    end
    r    = 64'd0;
    done = 1'b0;
    for (int k = 0; k < 64; k++) begin
      e = 64 - i * (2 * k + 1);
      if (!done && e < 0) begin
        done = 1'b1;
      end
      if (!done) begin
        term = (64'd1 << e) / 64'(2 * k + 1);
        if (term == 64'd0) begin
          done = 1'b1;
        end else if (k % 2 == 1) begin
          r = r - term;
        end else begin
          r = r + term;
        end
      end
    end
    prod = {64'd0, r} * {64'd0, TWO_OVER_PI};
    hi   = prod[127:64];
    return (hi + 64'd2) >> 2;
  endfunction

  // Matrix entry in Q58, magnitude truncated
  function automatic word_t coef_entry(int idx);
    word_t        n;
    logic [63:0]  m;
    logic [127:0] q;
    n = COEF_DEC[idx];
    m = n[63] ? 64'd0 - n : n;
    q = ({64'd0, m} << 48) / POW5_10;
    return n[63] ? word_t'(64'd0 - q[63:0]) : word_t'(q[63:0]);
  endfunction

  // Rotation input beyond a quarter turn is folded by a half turn
  function automatic logic rot_flip(word_t a);
    return (a > word_t'(64'd1 << 62)) || (a < -word_t'(64'd1 << 62));
  endfunction

endpackage

@@ hdl/equatorial_galactic_convert.sv @@
// Top level: equatorial/galactic sky-coordinate rotation pipeline.
// Accepts one position per clock while the output buffer is not full and returns one
// converted position per input, in order. The path runs through three chains of 60 CORDIC
// cells (sin/cos generation, longitude and latitude vectoring) and the four-stage 64-bit
// multipliers between them. A two-entry output buffer lets input continue while one result
// waits; the whole pipeline holds only when both entries are full. direction may be
// written only while no item is in flight.
module equatorial_galactic_convert import egc_pkg::*; #(
  parameter int ANGLE_WIDTH = 32,
  localparam int DATA_W = ((2 * ANGLE_WIDTH + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,     // direction
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [DATA_W-1:0] s_axis_tdata_i,  // lon_in, lat_in, zero pad
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [DATA_W-1:0] m_axis_tdata_o   // lon_out, lat_out, zero pad
);

  localparam int W   = ANGLE_WIDTH;
  localparam int LAT = 197;
  localparam int PAD = 64 - W;

  logic              dir_q;
  logic              en;
  logic              s_accept;
  logic              push;
  logic              pop;
  logic [LAT-1:0]    vld_q;
  logic [1:0]        cnt_q, cnt_d;
  logic [DATA_W-1:0] buf0_q, buf0_d, buf1_q, buf1_d;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
    end else if (cfg_we_i) begin
      dir_q <= cfg_wdata_i;
    end
  end

  assign en = (cnt_q != 2'd2);
  assign s_axis_tready_o = en;
  assign s_accept = s_axis_tvalid_i & en;

  // Valid marks travel alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_accept};
    end
  end

  // ---------------- sin/cos generation ----------------
  word_t   lon_ph, lat_ph;
  logic    lon_flip, lat_flip;
  cordic_t lon_st [CORDIC_IT+1];
  cordic_t lat_st [CORDIC_IT+1];
  logic    lon_flip_q, lat_flip_q;
  logic    lon_flip_dl, lat_flip_dl;

  assign lon_ph = word_t'({s_axis_tdata_i[W-1:0], {PAD{1'b0}}});
  assign lat_ph = word_t'({s_axis_tdata_i[2*W-1:W], {PAD{1'b0}}});
  assign lon_flip = rot_flip(lon_ph);
  assign lat_flip = rot_flip(lat_ph);

  // Load the chain heads: start at the gain, fold angles past a quarter turn
  always_ff @(posedge clk_i) begin
    if (en) begin
      lon_st[0]  <= '{x: GAIN_K, y: '0, z: lon_ph ^ {lon_flip, 63'd0}};
      lat_st[0]  <= '{x: GAIN_K, y: '0, z: lat_ph ^ {lat_flip, 63'd0}};
      lon_flip_q <= lon_flip;
      lat_flip_q <= lat_flip;
    end
  end

  for (genvar k = 0; k < CORDIC_IT; k++) begin : g_rot
    egc_cordic_cell #(.IDX(k), .VECTOR(1'b0)) u_lon (
      .clk_i(clk_i), .en_i(en), .st_i(lon_st[k]), .st_o(lon_st[k+1])
    );
    egc_cordic_cell #(.IDX(k), .VECTOR(1'b0)) u_lat (
      .clk_i(clk_i), .en_i(en), .st_i(lat_st[k]), .st_o(lat_st[k+1])
    );
  end

  egc_delay #(.WIDTH(2), .DEPTH(CORDIC_IT)) u_flip_dl (
    .clk_i(clk_i), .en_i(en), .d_i({lon_flip_q, lat_flip_q}), .q_o({lon_flip_dl, lat_flip_dl})
  );

  // Undo the fold
  word_t co_q, so_q, cl_q, sl_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      co_q <= lon_flip_dl ? -lon_st[CORDIC_IT].x : lon_st[CORDIC_IT].x;
      so_q <= lon_flip_dl ? -lon_st[CORDIC_IT].y : lon_st[CORDIC_IT].y;
      cl_q <= lat_flip_dl ? -lat_st[CORDIC_IT].x : lat_st[CORDIC_IT].x;
      sl_q <= lat_flip_dl ? -lat_st[CORDIC_IT].y : lat_st[CORDIC_IT].y;
    end
  end

  // ---------------- unit vector and rotation matrix ----------------
  word_t v_vec [3];
  word_t p_mat [9];
  word_t w_q [3];

  egc_smul #(.SHIFT(VEC_FRAC)) u_vx (
    .clk_i(clk_i), .en_i(en), .a_i(co_q), .b_i(cl_q), .p_o(v_vec[0])
  );
  egc_smul #(.SHIFT(VEC_FRAC)) u_vy (
    .clk_i(clk_i), .en_i(en), .a_i(so_q), .b_i(cl_q), .p_o(v_vec[1])
  );
  egc_delay #(.WIDTH(64), .DEPTH(SMUL_LAT)) u_vz_dl (
    .clk_i(clk_i), .en_i(en), .d_i(sl_q), .q_o(v_vec[2])
  );

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      localparam word_t E_FWD = coef_entry(r * 3 + c);
      localparam word_t E_TRN = coef_entry(c * 3 + r);
      word_t e;
      assign e = dir_q ? E_TRN : E_FWD;
      egc_smul #(.SHIFT(COEF_FRAC)) u_m (
        .clk_i(clk_i), .en_i(en), .a_i(e), .b_i(v_vec[c]), .p_o(p_mat[r*3+c])
      );
    end
  end

  // Accumulate each row
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        w_q[r] <= p_mat[r*3] + p_mat[r*3+1] + p_mat[r*3+2];
      end
    end
  end

  // ---------------- longitude vectoring ----------------
  cordic_t v1_st [CORDIC_IT+1];
  logic    base1_q, zero1_q, base1_dl, zero1_dl;
  word_t   ang1, ang1_dl, w2_dl, h;

  always_ff @(posedge clk_i) begin
    if (en) begin
      v1_st[0] <= '{x: w_q[0][63] ? -w_q[0] : w_q[0],
                    y: w_q[0][63] ? -w_q[1] : w_q[1], z: '0};
      base1_q  <= w_q[0][63];
      zero1_q  <= (w_q[0] == '0) && (w_q[1] == '0);
    end
  end

  for (genvar k = 0; k < CORDIC_IT; k++) begin : g_vec1
    egc_cordic_cell #(.IDX(k), .VECTOR(1'b1)) u_c (
      .clk_i(clk_i), .en_i(en), .st_i(v1_st[k]), .st_o(v1_st[k+1])
    );
  end

  egc_delay #(.WIDTH(2), .DEPTH(CORDIC_IT)) u_b1_dl (
    .clk_i(clk_i), .en_i(en), .d_i({base1_q, zero1_q}), .q_o({base1_dl, zero1_dl})
  );

  assign ang1 = zero1_dl ? '0 : word_t'({base1_dl, 63'd0}) + v1_st[CORDIC_IT].z;

  // Scale the xy magnitude back by the gain
  egc_smul #(.SHIFT(VEC_FRAC)) u_h (
    .clk_i(clk_i), .en_i(en), .a_i(v1_st[CORDIC_IT].x), .b_i(GAIN_K), .p_o(h)
  );
  egc_delay #(.WIDTH(64), .DEPTH(CORDIC_IT + 1 + SMUL_LAT)) u_w2_dl (
    .clk_i(clk_i), .en_i(en), .d_i(w_q[2]), .q_o(w2_dl)
  );
  egc_delay #(.WIDTH(64), .DEPTH(SMUL_LAT + 1 + CORDIC_IT)) u_lon_dl (
    .clk_i(clk_i), .en_i(en), .d_i(ang1), .q_o(ang1_dl)
  );

  // ---------------- latitude vectoring ----------------
  cordic_t v2_st [CORDIC_IT+1];
  logic    base2_q, zero2_q, base2_dl, zero2_dl;
  word_t   ang2, lat_sat, lon_rnd, lat_rnd;

  always_ff @(posedge clk_i) begin
    if (en) begin
      v2_st[0] <= '{x: h[63] ? -h : h, y: h[63] ? -w2_dl : w2_dl, z: '0};
      base2_q  <= h[63];
      zero2_q  <= (h == '0) && (w2_dl == '0);
    end
  end

  for (genvar k = 0; k < CORDIC_IT; k++) begin : g_vec2
    egc_cordic_cell #(.IDX(k), .VECTOR(1'b1)) u_c (
      .clk_i(clk_i), .en_i(en), .st_i(v2_st[k]), .st_o(v2_st[k+1])
    );
  end

  egc_delay #(.WIDTH(2), .DEPTH(CORDIC_IT)) u_b2_dl (
    .clk_i(clk_i), .en_i(en), .d_i({base2_q, zero2_q}), .q_o({base2_dl, zero2_dl})
  );

  assign ang2 = zero2_dl ? '0 : word_t'({base2_dl, 63'd0}) + v2_st[CORDIC_IT].z;

  // Clamp latitude to a quarter turn, round both angles to the output width
  always_comb begin
    lat_sat = ang2;
    if (ang2 > word_t'(64'd1 << 62)) begin
      lat_sat = word_t'(64'd1 << 62);
    end else if (ang2 < -word_t'(64'd1 << 62)) begin
      lat_sat = -word_t'(64'd1 << 62);
    end
    lon_rnd = ang1_dl + word_t'(64'd1 << (63 - W));
    lat_rnd = lat_sat + word_t'(64'd1 << (63 - W));
  end

  // ---------------- output buffer ----------------
  logic [DATA_W-1:0] res;
  assign res  = DATA_W'({lat_rnd[63 -: W], lon_rnd[63 -: W]});
  assign push = en & vld_q[LAT-1];
  assign pop  = m_axis_tvalid_o & m_axis_tready_i;

  always_comb begin
    buf0_d = buf0_q;
    buf1_d = buf1_q;
    cnt_d  = cnt_q + {1'b0, push} - {1'b0, pop};
    if (pop) begin
      if (cnt_q == 2'd2) begin
        buf0_d = buf1_q;
      end else if (push) begin
        buf0_d = res;
      end
    end else if (push) begin
      if (cnt_q == 2'd0) begin
        buf0_d = res;
      end else begin
        buf1_d = res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    buf0_q <= buf0_d;
    buf1_q <= buf1_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = buf0_q;

  // ---------------- checks ----------------
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("output buffer count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[LAT-1] && cnt_q == 2'd2 |=> vld_q[LAT-1])
    else $error("result dropped while buffer full");

  a_lat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(m_axis_tdata_o[2*W-1:W]) <= $signed(W'(1) <<< (W - 2)))
      && ($signed(m_axis_tdata_o[2*W-1:W]) >= -$signed(W'(1) <<< (W - 2))))
    else $error("latitude outside a quarter turn");

endmodule

@@ hdl/egc_delay.sv @@
// Enabled shift line that keeps side data aligned with the cell chains.
module egc_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  // Advance one tap per enabled cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        tap_q[k] <= tap_q[k-1];
      end
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

@@ hdl/egc_smul.sv @@
// Pipelined signed 64x64 multiply, rounded shift right with ties away from zero.
module egc_smul import egc_pkg::*; #(
  parameter int SHIFT = 60
) (
  input  logic  clk_i,
  input  logic  en_i,
  input  word_t a_i,
  input  word_t b_i,
  output word_t p_o
);

  localparam logic [127:0] ROUND_C = 128'd1 << (SHIFT - 1);

  logic         neg_a_q, neg_b_q, neg_c_q;
  logic [63:0]  ua_q, ub_q;
  logic [63:0]  pp0_q, pp1_q, pp2_q, pp3_q;
  logic [127:0] sum_q;
  word_t        p_q;
  logic [127:0] sum_d;
  logic [127:0] shifted;
  logic [62:0]  mag;

  // Sum partial products with the rounding bias
  assign sum_d = {pp3_q, pp0_q} + {32'd0, pp1_q, 32'd0} + {32'd0, pp2_q, 32'd0} + ROUND_C;
  assign shifted = sum_q >> SHIFT;
  assign mag = shifted[62:0];

  // Magnitudes, 32x32 partial products, wide sum, sign restore
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_a_q <= a_i[63] ^ b_i[63];
      ua_q    <= a_i[63] ? 64'd0 - a_i : a_i;
      ub_q    <= b_i[63] ? 64'd0 - b_i : b_i;
      neg_b_q <= neg_a_q;
      pp0_q   <= 64'(ua_q[31:0]) * 64'(ub_q[31:0]);
      pp1_q   <= 64'(ua_q[31:0]) * 64'(ub_q[63:32]);
      pp2_q   <= 64'(ua_q[63:32]) * 64'(ub_q[31:0]);
      pp3_q   <= 64'(ua_q[63:32]) * 64'(ub_q[63:32]);
      neg_c_q <= neg_b_q;
      sum_q   <= sum_d;
      p_q     <= neg_c_q ? word_t'(64'd0 - {1'b0, mag}) : word_t'({1'b0, mag});
    end
  end

  assign p_o = p_q;

endmodule

@@ hdl/egc_cordic_cell.sv @@
// One CORDIC micro-rotation, in rotation or vectoring mode, registered.
module egc_cordic_cell import egc_pkg::*; #(
  parameter int IDX    = 0,
  parameter bit VECTOR = 1'b0
) (
  input  logic    clk_i,
  input  logic    en_i,
  input  cordic_t st_i,
  output cordic_t st_o
);

  localparam word_t ATAN = word_t'(atan_entry(IDX));

  word_t   dx, dy;
  logic    fwd;
  cordic_t st_d, st_q;

  assign dx = st_i.y >>> IDX;
  assign dy = st_i.x >>> IDX;
  // Rotate toward zero residual angle, or toward the x axis
  assign fwd = VECTOR ? st_i.y[63] : ~st_i.z[63];

  always_comb begin
    if (fwd) begin
      st_d.x = st_i.x - dx;
      st_d.y = st_i.y + dy;
      st_d.z = st_i.z - ATAN;
    end else begin
      st_d.x = st_i.x + dx;
      st_d.y = st_i.y - dy;
      st_d.z = st_i.z + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;

endmodule

@@ sim/equatorial_galactic_convert_tb.sv @@
// Testbench for the equatorial/galactic coordinate converter: directed and random positions, bit-exact predictor.
module equatorial_galactic_convert_tb;

  typedef logic signed [63:0] s64_t;

  typedef struct packed {
    logic [31:0] lon;
    logic [31:0] lat;
  } sky_pos_t;

  localparam int   ITER     = 60;
  localparam s64_t QUARTER  = s64_t'(64'h4000_0000_0000_0000);
  localparam int   N_RANDOM = 1100;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i;   // lon_in, lat_in
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [63:0] m_axis_tdata_o;   // lon_out, lat_out

  equatorial_galactic_convert u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Rotation matrix entries in units of 1e-10, row major
  localparam s64_t MAT_DEC [9] = '{
    -64'sd548755604,  64'sd4941094279, -64'sd8676661490,
    -64'sd8734370902, -64'sd4448296300, -64'sd1980763734,
    -64'sd4838350155,  64'sd7469822445,  64'sd4559837762
  };

  logic [63:0] atan_phase [ITER];
  s64_t        mat_q58 [9];
  s64_t        inv_gain;
  logic        dir_q;

  sky_pos_t    pending_pos[$];
  int          n_mismatch;
  int          gap_max_in;
  int          gap_max_out;

  // Product scaled down by 2^s, rounded to nearest with ties away from zero
  function automatic s64_t mul_round(s64_t a, s64_t b, int s);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] p;
    logic [62:0]  r;
    ua = a[63] ? 64'd0 - a : a;
    ub = b[63] ? 64'd0 - b : b;
    p  = {64'd0, ua} * {64'd0, ub};
    p  = (p + (128'd1 << (s - 1))) >> s;
    r  = p[62:0];
    return (a[63] ^ b[63]) ? s64_t'(64'd0 - {1'b0, r}) : s64_t'({1'b0, r});
  endfunction

  // Build the arctangent phases, the CORDIC gain and the Q58 matrix
  function automatic void build_consts();
    logic [63:0]  r;
    logic [63:0]  term;
    logic [127:0] prod;
    logic [63:0]  m;
    s64_t         p;
    s64_t         y;
    s64_t         t;
    int           e;
    atan_phase[0] = 64'd1 << 61;
    for (int i = 1; i < ITER; i++) begin
      r = 0;
      for (int k = 0; k < 64; k++) begin
        e = 64 - i * (2 * k + 1);
        if (e < 0) break;
        term = (64'd1 << e) / 64'(2 * k + 1);
        if (term == 0) break;
        if (k % 2 == 1) r = r - term;
        else r = r + term;
      end
      prod = {64'd0, r} * {64'd0, 64'hA2F9836E4E44152A};
      atan_phase[i] = (prod[127:64] + 64'd2) >> 2;
    end
    p = s64_t'(64'd1 << 60);
    for (int i = 0; i < ITER; i++) begin
      if (2 * i < 63) p = p + (p >>> (2 * i));
    end
    y = s64_t'(64'd1 << 59);
    for (int i = 0; i < 8; i++) begin
      t = mul_round(y, y, 60);
      t = mul_round(p, t, 60);
      t = s64_t'(64'd3 << 60) - t;
      y = mul_round(y, t, 61);
    end
    inv_gain = y;
    for (int i = 0; i < 9; i++) begin
      m    = MAT_DEC[i][63] ? 64'd0 - MAT_DEC[i] : MAT_DEC[i];
      prod = ({64'd0, m} << 48) / 128'd9765625;
      mat_q58[i] = MAT_DEC[i][63] ? s64_t'(64'd0 - prod[63:0]) : s64_t'(prod[63:0]);
    end
  endfunction

  // Cosine and sine of a phase, folded into the right half plane first
  function automatic void sin_cos(input logic [63:0] ph, output s64_t c, output s64_t s);
    s64_t a;
    s64_t x;
    s64_t y;
    s64_t z;
    s64_t dx;
    s64_t dy;
    logic fold;
    a    = ph;
    fold = (a > QUARTER) || (a < -QUARTER);
    if (fold) a = ph + 64'h8000_0000_0000_0000;
    x = inv_gain;
    y = 0;
    z = a;
    for (int i = 0; i < ITER; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - s64_t'(atan_phase[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + s64_t'(atan_phase[i]);
      end
    end
    c = fold ? -x : x;
    s = fold ? -y : y;
  endfunction

  // Angle of (x, y) as a phase, and the gain-scaled magnitude
  function automatic void vector_angle(input s64_t x0, input s64_t y0,
                                       output logic [63:0] ang, output s64_t mag);
    s64_t        x;
    s64_t        y;
    s64_t        z;
    s64_t        dx;
    s64_t        dy;
    logic [63:0] base;
    x    = x0;
    y    = y0;
    z    = 0;
    base = 0;
    if (x == 0 && y == 0) begin
      ang = 0;
      mag = 0;
      return;
    end
    if (x < 0) begin
      x    = -x;
      y    = -y;
      base = 64'h8000_0000_0000_0000;
    end
    for (int i = 0; i < ITER; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x = x - dx; y = y + dy; z = z - s64_t'(atan_phase[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + s64_t'(atan_phase[i]);
      end
    end
    ang = base + z;
    mag = x;
  endfunction

  function automatic logic [31:0] phase_round(logic [63:0] ph);
    logic [63:0] t;
    t = ph + (64'd1 << 31);
    return t[63:32];
  endfunction

  // Rotate one sky position into the other frame
  function automatic sky_pos_t convert_pos(sky_pos_t pin, logic dir);
    s64_t        cl;
    s64_t        sl;
    s64_t        co;
    s64_t        so;
    s64_t        v [3];
    s64_t        w [3];
    s64_t        m;
    s64_t        h;
    s64_t        ls;
    logic [63:0] lon_ph;
    logic [63:0] lat_ph;
    sky_pos_t    res;
    sin_cos({pin.lat, 32'd0}, cl, sl);
    sin_cos({pin.lon, 32'd0}, co, so);
    v[0] = mul_round(co, cl, 60);
    v[1] = mul_round(so, cl, 60);
    v[2] = sl;
    for (int r = 0; r < 3; r++) begin
      w[r] = 0;
      for (int c = 0; c < 3; c++) begin
        w[r] = w[r] + mul_round(dir ? mat_q58[c * 3 + r] : mat_q58[r * 3 + c], v[c], 58);
      end
    end
    vector_angle(w[0], w[1], lon_ph, m);
    h = mul_round(m, inv_gain, 60);
    vector_angle(h, w[2], lat_ph, m);
    ls = lat_ph;
    if (ls > QUARTER) ls = QUARTER;
    if (ls < -QUARTER) ls = -QUARTER;
    res.lon = phase_round(lon_ph);
    res.lat = phase_round(ls);
    return res;
  endfunction

  // Directed positions: extremes, poles, wrap at pi, latitude at and just inside the nominal range edges
  localparam sky_pos_t DIRECTED [20] = '{
    '{32'h0000_0000, 32'h0000_0000}, '{32'h8000_0000, 32'h0000_0000},
    '{32'h7FFF_FFFF, 32'h0000_0000}, '{32'h4000_0000, 32'h0000_0000},
    '{32'hC000_0000, 32'h0000_0000}, '{32'h0000_0000, 32'h4000_0000},
    '{32'h0000_0000, 32'hC000_0000}, '{32'h8000_0000, 32'h4000_0000},
    '{32'h7FFF_FFFF, 32'hC000_0000}, '{32'hFFFF_FFFF, 32'h3FFF_FFFF},
    '{32'h0000_0001, 32'hC000_0001}, '{32'h2000_0000, 32'h2000_0000},
    '{32'hE000_0000, 32'hE000_0000}, '{32'h5555_5555, 32'h1555_5555},
    '{32'hAAAA_AAAA, 32'hEAAA_AAAA}, '{32'h3C71_C71C, 32'h1F6B_89A3},
    '{32'hC71C_71C7, 32'h0B61_1EF4}, '{32'h7FFF_FFFE, 32'h3FFF_FFFE},
    '{32'h8000_0001, 32'h0000_0001}, '{32'h1234_5678, 32'hF0ED_CBA9}
  };

  // Clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Send one position, hold until the transfer completes; valid stays up for the next one
  task automatic send_pos(sky_pos_t p);
    int gap;
    gap = $urandom_range(0, gap_max_in);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {p.lat, p.lon};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_pos.push_back(convert_pos(p, dir_q));
  endtask

  // Drop input valid after the last transfer of a run
  task automatic idle_input();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  // Wait for the pipeline to drain, then write direction
  task automatic set_direction(logic d);
    idle_input();
    while (pending_pos.size() != 0) @(posedge clk_i);
    repeat (210) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= d;
    dir_q       = d;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Draw a stall for each result on the output side
  initial begin
    int stall;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, gap_max_out);
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready_i <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    sky_pos_t got;
    sky_pos_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tdata_o[31:0], m_axis_tdata_o[63:32]};
      if (pending_pos.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result lon=%h lat=%h", got.lon, got.lat);
      end else begin
        want = pending_pos.pop_front();
        if (got.lon !== want.lon || got.lat !== want.lat) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: lon exp %h got %h, lat exp %h got %h",
                     want.lon, got.lon, want.lat, got.lat);
        end
      end
    end
  end

  // Main sequence
  initial begin
    sky_pos_t p;
    int       phase_items;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    dir_q           = 1'b0;
    n_mismatch      = 0;
    gap_max_in      = 0;
    gap_max_out     = 0;
    build_consts();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows under both directions, reset value first
    for (int d = 0; d < 2; d++) begin
      if (d == 1) set_direction(1'b1);
      gap_max_in  = 6 * d;
      gap_max_out = 6 * d;
      foreach (DIRECTED[i]) send_pos(DIRECTED[i]);
    end

    // Random phases, alternating direction and idling pressure
    for (int ph = 0; ph < 4; ph++) begin
      set_direction(ph[0]);
      gap_max_in  = (ph == 1) ? 0 : 6;
      gap_max_out = (ph == 2) ? 0 : 6;
      phase_items = N_RANDOM / 4;
      for (int n = 0; n < phase_items; n++) begin
        p.lon = $urandom();
        p.lat = 32'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
        send_pos(p);
      end
    end

    idle_input();
    while (pending_pos.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
    if (n_mismatch == 0 && pending_pos.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(12 * 400000);
    $display("tb: failure");
    $finish;
  end

endmodule
